@@ rtl/assert_macros.svh @@
// Concurrent assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define BMHQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another one on the same edge.
`define BMHQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define BMHQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bmhq_pkg.sv @@
// Types, codes and sizes shared by the heap queue engine and top level.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int POS_W    = 9;
  localparam int TAG_W    = 8;
  localparam int PRIO_W   = 8;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CHANGE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_RM_ROOT,
    ST_RM_LAST,
    ST_DN_CHK,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_DN_CMP,
    ST_CH_OLD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } heap_entry_t;

  typedef struct packed {
    func_t             func;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [POS_W-1:0]  pos;
  } bmhq_req_t;

  typedef struct packed {
    status_t           status;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  count;
  } bmhq_res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } bmhq_stat_t;

endpackage

`default_nettype wire

@@ rtl/bmhq_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module bmhq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bmhq_engine.sv @@
// Heap sequencer: decodes one operation and, where it needs one, runs sift-up or sift-down on the RAM.
`default_nettype none

module bmhq_engine import bmhq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bmhq_req_t         req,
  input  logic              res_ready,
  output bmhq_stat_t        stat,
  output bmhq_res_t         res,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output heap_entry_t       mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  input  heap_entry_t       mem_rdata
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   cur_pos_r, cur_pos_nxt;
  heap_entry_t        cur_val_r, cur_val_nxt;
  heap_entry_t        child_r, child_nxt;
  logic [CNT_W-1:0]   child_pos_r, child_pos_nxt;
  logic [PRIO_W-1:0]  prio_r, prio_nxt;
  status_t            status_r, status_nxt;
  logic [TAG_W-1:0]   otag_r, otag_nxt;
  logic [PRIO_W-1:0]  oprio_r, oprio_nxt;

  logic               ins_ok, rm_ok, ch_ok;
  logic [CNT_W-1:0]   parent_pos;
  logic [CNT_W:0]     left_pos;
  logic               left_past, left_inner;
  logic [ADDR_W-1:0]  cur_addr;
  logic               up_swap, dn_swap, right_wins;

  assign ins_ok     = count_r < CNT_W'(CAPACITY);
  assign rm_ok      = count_r != '0;
  assign ch_ok      = (req.pos != '0) && (CNT_W'(req.pos) <= count_r);
  assign parent_pos = cur_pos_r >> 1;
  assign left_pos   = {cur_pos_r, 1'b0};
  assign left_past  = left_pos > {1'b0, count_r};
  assign left_inner = left_pos < {1'b0, count_r};
  assign cur_addr   = ADDR_W'(cur_pos_r - CNT_W'(1));
  assign up_swap    = cur_val_r.prio > mem_rdata.prio;
  assign dn_swap    = child_r.prio > cur_val_r.prio;
  assign right_wins = mem_rdata.prio > child_r.prio;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (req.func)
            FUNC_INSERT: state_nxt = ins_ok ? ST_UP_CHK : ST_DONE;
            FUNC_REMOVE: state_nxt = rm_ok ? ST_RM_ROOT : ST_DONE;
            FUNC_CHANGE: state_nxt = ch_ok ? ST_CH_OLD : ST_DONE;
            FUNC_NOP:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_UP_CHK:   state_nxt = (cur_pos_r == CNT_W'(1)) ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP:   state_nxt = up_swap ? ST_UP_CHK : ST_DONE;
      ST_RM_ROOT:  state_nxt = ST_RM_LAST;
      ST_RM_LAST:  state_nxt = ST_DN_CHK;
      ST_DN_CHK:   state_nxt = left_past ? ST_DONE : ST_DN_LEFT;
      ST_DN_LEFT:  state_nxt = left_inner ? ST_DN_RIGHT : ST_DN_CMP;
      ST_DN_RIGHT: state_nxt = ST_DN_CMP;
      ST_DN_CMP:   state_nxt = dn_swap ? ST_DN_CHK : ST_DONE;
      ST_CH_OLD: begin
        if (prio_r > mem_rdata.prio) begin
          state_nxt = ST_UP_CHK;
        end else if (prio_r < mem_rdata.prio) begin
          state_nxt = ST_DN_CHK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE:     state_nxt = res_ready ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Memory port controls and status
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = cur_val_r;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && req.func == FUNC_REMOVE && rm_ok) begin
          mem_re = 1'b1;
        end else if (start && req.func == FUNC_CHANGE && ch_ok) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(req.pos - POS_W'(1));
        end
      end
      ST_UP_CHK: begin
        if (cur_pos_r == CNT_W'(1)) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(parent_pos - CNT_W'(1));
        end
      end
      ST_UP_CMP: begin
        // pull the parent down, or settle the moving entry here
        mem_we    = 1'b1;
        mem_wdata = up_swap ? mem_rdata : cur_val_r;
      end
      ST_RM_ROOT: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(count_r - CNT_W'(1));
      end
      ST_DN_CHK: begin
        if (left_past) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(left_pos - (CNT_W + 1)'(1));
        end
      end
      ST_DN_LEFT: begin
        if (left_inner) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(left_pos);
        end
      end
      ST_DN_CMP: begin
        // lift the larger child up, or settle the moving entry here
        mem_we    = 1'b1;
        mem_wdata = dn_swap ? child_r : cur_val_r;
      end
      ST_CH_OLD: begin
        if (prio_r == mem_rdata.prio) begin
          mem_we    = 1'b1;
          mem_wdata = '{tag: mem_rdata.tag, prio: prio_r};
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.idle      = state_r == ST_IDLE;
  assign stat.res_valid = state_r == ST_DONE;
  assign res            = '{status: status_r, tag: otag_r, prio: oprio_r, count: count_r};

  // Datapath next values
  always_comb begin
    count_nxt     = count_r;
    cur_pos_nxt   = cur_pos_r;
    cur_val_nxt   = cur_val_r;
    child_nxt     = child_r;
    child_pos_nxt = child_pos_r;
    prio_nxt      = prio_r;
    status_nxt    = status_r;
    otag_nxt      = otag_r;
    oprio_nxt     = oprio_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          prio_nxt    = req.prio;
          status_nxt  = STAT_OK;
          otag_nxt    = '0;
          oprio_nxt   = '0;
          cur_pos_nxt = CNT_W'(req.pos);
          case (req.func)
            FUNC_INSERT: begin
              if (ins_ok) begin
                count_nxt   = count_r + CNT_W'(1);
                cur_pos_nxt = count_r + CNT_W'(1);
                cur_val_nxt = '{tag: req.tag, prio: req.prio};
              end else begin
                status_nxt = STAT_FULL;
              end
            end
            FUNC_REMOVE: if (!rm_ok) status_nxt = STAT_EMPTY;
            FUNC_CHANGE: if (!ch_ok) status_nxt = STAT_RANGE;
            default: begin
            end
          endcase
        end
      end
      ST_UP_CMP: if (up_swap) cur_pos_nxt = parent_pos;
      ST_RM_ROOT: begin
        otag_nxt  = mem_rdata.tag;
        oprio_nxt = mem_rdata.prio;
      end
      ST_RM_LAST: begin
        // last entry goes to the root and sinks from there
        cur_val_nxt = mem_rdata;
        cur_pos_nxt = CNT_W'(1);
        count_nxt   = count_r - CNT_W'(1);
      end
      ST_DN_LEFT: begin
        child_nxt     = mem_rdata;
        child_pos_nxt = CNT_W'(left_pos);
      end
      ST_DN_RIGHT: begin
        if (right_wins) begin
          child_nxt     = mem_rdata;
          child_pos_nxt = CNT_W'(left_pos) + CNT_W'(1);
        end
      end
      ST_DN_CMP: if (dn_swap) cur_pos_nxt = child_pos_r;
      ST_CH_OLD: cur_val_nxt = '{tag: mem_rdata.tag, prio: prio_r};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_pos_r   <= cur_pos_nxt;
    cur_val_r   <= cur_val_nxt;
    child_r     <= child_nxt;
    child_pos_r <= child_pos_nxt;
    prio_r      <= prio_nxt;
    status_r    <= status_nxt;
    otag_r      <= otag_nxt;
    oprio_r     <= oprio_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/binary_max_heap_queue.sv @@
// Top level of the binary max-heap priority queue with stream ports.
//
//  channel | dir | tdata (low bit up)                       | tuser
//  --------+-----+------------------------------------------+--------------
//  in_     | in  | item_tag[7:0] priority_req[7:0] pos[8:0] | func[1:0]
//  out_    | out | out_tag[7:0] out_priority[7:0] count[8:0]| status[1:0]
//
// One item is worked at a time; in_tready is high only while the sequencer idles.
// A rejected item or a no-op goes straight to the result; insert sifts up, and remove
// moves the last entry to the root and sifts it down; change sifts up or down as the
// priority rises or falls, and rewrites the entry in place if it is unchanged.
// The single RAM read port makes sift-down read the two children of a level in turn.
// A held result stalls only the next item's completion; reset empties the heap, not the RAM.
`default_nettype none
`include "assert_macros.svh"

module binary_max_heap_queue import bmhq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // item_tag, priority_req, position, zero fill
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_tag, out_priority, entry_count, zero fill
  output logic [1:0]  out_tuser   // status
);

  bmhq_req_t         req;
  bmhq_res_t         res;
  bmhq_stat_t        eng_stat;
  logic              start;
  logic              res_ready;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  heap_entry_t       mem_wdata, mem_rdata;

  logic              out_valid_r, out_valid_nxt;
  bmhq_res_t         out_res_r, out_res_nxt;

  // Unpack the incoming item
  assign req.func = func_t'(in_tuser);
  assign req.tag  = in_tdata[7:0];
  assign req.prio = in_tdata[15:8];
  assign req.pos  = in_tdata[24:16];

  assign in_tready = eng_stat.idle;
  assign start     = in_tvalid && in_tready;

  // Take a result whenever the output register is empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (eng_stat.res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'd0, out_res_r.count, out_res_r.prio, out_res_r.tag};

  bmhq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .res_ready (res_ready),
    .stat      (eng_stat),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bmhq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(heap_entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Count never exceeds the heap size
  `BMHQ_ASSERT(a_count_range, !out_valid_r || out_res_r.count <= CNT_W'(CAPACITY), "count over capacity")
  // An accepted item blocks the input until its work is done
  `BMHQ_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second item taken while busy")
  // Full is reported only with the heap at capacity
  `BMHQ_ASSERT_IMP(a_full_count, out_valid_r && out_res_r.status == STAT_FULL, out_res_r.count == CNT_W'(CAPACITY), "full flagged below capacity")
  // Removed entry fields are zero on any failed item
  `BMHQ_ASSERT_IMP(a_zero_fields, out_valid_r && out_res_r.status != STAT_OK, out_res_r.tag == '0 && out_res_r.prio == '0, "entry fields set on failure")

endmodule

`default_nettype wire
